/* rtl/slcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_pkg
// shared types and constants of the sync / length / crc-32 deframer
// ----------------------------------------------------------------------------
package slcd_pkg;

  localparam int unsigned PADDR_W = 4;

  localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND = 8'h55;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_SYNC2   = 3'd1;
  localparam logic [2:0] PH_LEN_LO  = 3'd2;
  localparam logic [2:0] PH_LEN_HI  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_TRAILER = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_CRC_BAD  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT  = 2'd3;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd0;
  localparam logic [1:0] REG_SYNC_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_BYTE_TIMEOUT = 2'd2;

  localparam logic [15:0] RST_MAX_PAYLOAD  = 16'd1024;
  localparam logic [15:0] RST_SYNC_TIMEOUT = 16'd100;
  localparam logic [15:0] RST_BYTE_TIMEOUT = 16'd1000;

  typedef struct packed {
    logic [15:0] max_payload;
    logic [15:0] sync_timeout;
    logic [15:0] byte_timeout;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [15:0] frame_length;
  } res_t;

endpackage

/* rtl/slcd_crc_byte.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_crc_byte
// one byte step of the reflected crc-32, eight bit steps unrolled
// ----------------------------------------------------------------------------
module slcd_crc_byte
  import slcd_pkg::*;
(
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

/* rtl/slcd_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_cfg
// apb register file: max payload, sync timeout, byte timeout
// ----------------------------------------------------------------------------
module slcd_cfg
  import slcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_payload  <= RST_MAX_PAYLOAD;
      cfg.sync_timeout <= RST_SYNC_TIMEOUT;
      cfg.byte_timeout <= RST_BYTE_TIMEOUT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_PAYLOAD:  cfg.max_payload  <= pwdata[15:0];
        REG_SYNC_TIMEOUT: cfg.sync_timeout <= pwdata[15:0];
        REG_BYTE_TIMEOUT: cfg.byte_timeout <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_PAYLOAD:  prdata = {16'd0, cfg.max_payload};
      REG_SYNC_TIMEOUT: prdata = {16'd0, cfg.sync_timeout};
      REG_BYTE_TIMEOUT: prdata = {16'd0, cfg.byte_timeout};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/slcd_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_fsm
// frame state: sync hunt, length, payload with crc, trailer, tick timeouts
// ----------------------------------------------------------------------------
module slcd_fsm
  import slcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       has_res,
  output res_t       res
);

  logic [2:0]  phase, phase_next;
  logic [31:0] running_crc, running_crc_next;
  logic [15:0] announced_length, announced_length_next;
  logic [15:0] byte_count, byte_count_next;
  logic [31:0] trailer_crc, trailer_crc_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  logic [31:0] crc_upd;
  logic [15:0] ticks_inc;
  logic [15:0] limit;
  logic [15:0] count_inc;
  logic [15:0] len_full;

  slcd_crc_byte u_crc (
    .crc_in  (running_crc),
    .data    (rx_byte),
    .crc_out (crc_upd)
  );

  assign ticks_inc = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;
  assign limit     = (phase == PH_SYNC2) ? cfg.sync_timeout : cfg.byte_timeout;
  assign count_inc = byte_count + 16'd1;
  assign len_full  = {rx_byte, announced_length[7:0]};

  always_comb begin
    phase_next            = phase;
    running_crc_next      = running_crc;
    announced_length_next = announced_length;
    byte_count_next       = byte_count;
    trailer_crc_next      = trailer_crc;
    idle_ticks_next       = idle_ticks;
    has_res               = 1'b0;
    res                   = '0;

    if (req_type == REQ_TICK) begin
      if (phase == PH_HUNT || phase > PH_TRAILER) begin
        phase_next      = PH_HUNT;
        idle_ticks_next = 16'd0;
        byte_count_next = 16'd0;
      end else if (ticks_inc < limit) begin
        idle_ticks_next = ticks_inc;
      end else begin
        phase_next      = PH_HUNT;
        idle_ticks_next = 16'd0;
        byte_count_next = 16'd0;
        if (phase != PH_SYNC2) begin
          has_res      = 1'b1;
          res.kind     = KIND_STATUS;
          res.status   = ST_TIMEOUT;
          res.frame_length = (phase inside {PH_LEN_LO, PH_LEN_HI}) ?
                             16'd0 : announced_length;
        end
      end
    end else begin
      idle_ticks_next = 16'd0;
      case (phase)
        PH_SYNC2: begin
          byte_count_next = 16'd0;
          if (rx_byte == SYNC_SECOND) begin
            phase_next            = PH_LEN_LO;
            announced_length_next = 16'd0;
            running_crc_next      = CRC_INIT;
            trailer_crc_next      = 32'd0;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_LEN_LO: begin
          announced_length_next = {8'd0, rx_byte};
          phase_next            = PH_LEN_HI;
          byte_count_next       = 16'd0;
        end
        PH_LEN_HI: begin
          announced_length_next = len_full;
          byte_count_next       = 16'd0;
          if (len_full > cfg.max_payload) begin
            phase_next       = PH_HUNT;
            has_res          = 1'b1;
            res.kind         = KIND_STATUS;
            res.status       = ST_TOO_LONG;
            res.frame_length = len_full;
          end else begin
            phase_next = (len_full == 16'd0) ? PH_TRAILER : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          running_crc_next = crc_upd;
          has_res          = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = rx_byte;
          res.frame_length = announced_length;
          if (count_inc >= announced_length) begin
            phase_next      = PH_TRAILER;
            byte_count_next = 16'd0;
          end else begin
            byte_count_next = count_inc;
          end
        end
        PH_TRAILER: begin
          trailer_crc_next = trailer_crc |
                             ({24'd0, rx_byte} << {byte_count[1:0], 3'b000});
          if (count_inc >= 16'd4) begin
            phase_next       = PH_HUNT;
            byte_count_next  = 16'd0;
            has_res          = 1'b1;
            res.kind         = KIND_STATUS;
            res.status       = (trailer_crc_next == ~running_crc) ? ST_OK : ST_CRC_BAD;
            res.frame_length = announced_length;
          end else begin
            byte_count_next = count_inc;
          end
        end
        default: begin
          byte_count_next = 16'd0;
          phase_next      = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      running_crc      <= CRC_INIT;
      announced_length <= 16'd0;
      byte_count       <= 16'd0;
      trailer_crc      <= 32'd0;
      idle_ticks       <= 16'd0;
    end else if (accept) begin
      phase            <= phase_next;
      running_crc      <= running_crc_next;
      announced_length <= announced_length_next;
      byte_count       <= byte_count_next;
      trailer_crc      <= trailer_crc_next;
      idle_ticks       <= idle_ticks_next;
    end
  end

endmodule

/* rtl/slcd_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_out_reg
// result register with valid/ready towards the receiver
// ----------------------------------------------------------------------------
module slcd_out_reg
  import slcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  res_t        res_in,
  input  logic        res_ready,
  output logic        res_valid,
  output logic        space,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [1:0]  status,
  output logic [15:0] frame_length
);

  res_t res_q;

  assign space        = !res_valid || res_ready;
  assign kind         = res_q.kind;
  assign payload_byte = res_q.payload_byte;
  assign status       = res_q.status;
  assign frame_length = res_q.frame_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

/* rtl/sync_length_crc_deframer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_crc_deframer_unit
// deframer for 0xaa 0x55 / 16-bit length / payload / crc-32 frames
// ----------------------------------------------------------------------------
// request channel (req_valid/req_ready): one beat is a received byte or a
//   one millisecond tick, chosen by req_type
// result channel (res_valid/res_ready): a payload byte (kind 0) for each
//   payload byte received, or an end of frame status (kind 1): ok, too long,
//   crc mismatch or byte timeout
// a request beat gives at most one result beat, valid in the cycle after acceptance
// one request beat per cycle; req_ready is high while the result register is
//   empty or being taken, so a stalled receiver holds off requests only when
//   a result is waiting
// a beat that yields no result still advances the frame state
// apb port holds max_payload, sync_timeout and byte_timeout; write only while
//   no beat is in flight
// reset: hunting for sync, crc all ones, registers at 1024 / 100 / 1000,
//   result register empty; ready from the first cycle after reset
// ----------------------------------------------------------------------------
module sync_length_crc_deframer_unit
  import slcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               req_type,
  input  logic [7:0]         rx_byte,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               kind,
  output logic [7:0]         payload_byte,
  output logic [1:0]         status,
  output logic [15:0]        frame_length,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg;
  res_t res;
  logic has_res;
  logic accept;
  logic space;

  assign req_ready = space;
  assign accept    = req_valid && space;

  slcd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slcd_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req_type (req_type),
    .rx_byte  (rx_byte),
    .cfg      (cfg),
    .has_res  (has_res),
    .res      (res)
  );

  slcd_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && has_res),
    .res_in       (res),
    .res_ready    (res_ready),
    .res_valid    (res_valid),
    .space        (space),
    .kind         (kind),
    .payload_byte (payload_byte),
    .status       (status),
    .frame_length (frame_length)
  );

endmodule

/* rtl/slcd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_checker
// port-level checks of the deframer, bound to the top level
// ----------------------------------------------------------------------------
module slcd_checker
  import slcd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        kind,
  input logic [7:0]  payload_byte,
  input logic [1:0]  status,
  input logic [15:0] frame_length
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(payload_byte)
      && $stable(status) && $stable(frame_length))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> req_ready)
    else $error("request stalled with empty result register");

  a_new_res_from_req: assert property (@(posedge clk) disable iff (rst)
    res_valid && !($past(res_valid) && !$past(res_ready)) |->
      $past(req_valid && req_ready))
    else $error("result beat without an accepted request");

  a_payload_status_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_PAYLOAD |-> status == ST_OK)
    else $error("payload beat with non-zero status");

  a_status_byte_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_STATUS |-> payload_byte == 8'd0)
    else $error("status beat with non-zero payload byte");

endmodule

bind sync_length_crc_deframer_unit slcd_checker u_slcd_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_ready    (req_ready),
  .res_valid    (res_valid),
  .res_ready    (res_ready),
  .kind         (kind),
  .payload_byte (payload_byte),
  .status       (status),
  .frame_length (frame_length)
);
